// File: hw/rtl/hrs_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and pattern tables for the HTTP request header scanner.
// No dependencies; the other files of the block, apart from hrs_fifo, refer to it by scoped names.
package hrs_pkg;

    localparam int OUT_BYTES_W = 13;
    localparam int MAX_HDR_W   = 13;
    localparam int MAX_LINE_W  = 8;
    localparam int CFG_DATA_W  = 13;

    // Configuration register indexes
    localparam logic CFG_MAX_HEADER = 1'b0;
    localparam logic CFG_MAX_LINE   = 1'b1;

    localparam logic [MAX_HDR_W-1:0]  MAX_HDR_RESET  = 13'd4096;
    localparam logic [MAX_LINE_W-1:0] MAX_LINE_RESET = 8'd255;

    // Route status codes
    localparam logic [2:0] ST_OK_ROOT   = 3'd0;
    localparam logic [2:0] ST_OK_HEALTH = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_BAD_REQ   = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE = 3'd4;

    // Parser phase
    localparam logic PH_REQ = 1'b0;
    localparam logic PH_HDR = 1'b1;

    // Terminator progress codes
    localparam logic [1:0] TP_IDLE   = 2'd0;
    localparam logic [1:0] TP_CR     = 2'd1;
    localparam logic [1:0] TP_CRLF   = 2'd2;
    localparam logic [1:0] TP_CRLFCR = 2'd3;

    localparam logic [1:0] TOK_METHOD = 2'd1;
    localparam logic [1:0] TOK_PATH   = 2'd2;
    localparam logic [1:0] TOK_LAST   = 2'd3;

    localparam logic [2:0] METHOD_FULL = 3'd3;
    localparam logic [2:0] METHOD_DEAD = 3'd7;
    localparam logic [3:0] PATH_ROOT   = 4'd1;
    localparam logic [3:0] PATH_FULL   = 4'd7;
    localparam logic [3:0] PATH_DEAD   = 4'd15;
    localparam logic [3:0] NAME_FULL   = 4'd11;
    localparam logic [3:0] NAME_DEAD   = 4'd15;
    localparam logic [2:0] VALUE_FULL  = 3'd5;
    localparam logic [2:0] VALUE_DEAD  = 3'd7;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NUL = 8'h00;

    // One classified byte as handed from the front to the back
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] lower;
        logic       is_cr;
        logic       is_lf;
        logic       is_space;
        logic       is_blank;
        logic       is_nul;
        logic       first;
    } hrs_sym_t;

    typedef struct packed {
        logic [2:0]             status;
        logic                   keep;
        logic [OUT_BYTES_W-1:0] bytes;
    } hrs_result_t;

    // Parser state apart from the two counters
    typedef struct packed {
        logic       phase;
        logic [1:0] ti;
        logic [2:0] mp;
        logic [3:0] pp;
        logic [3:0] nm;
        logic [2:0] vp;
        logic       keep;
        logic [1:0] tp;
        logic       line_bad;
        logic       in_token;
        logic       nul_seen;
    } hrs_pstate_t;

    localparam hrs_pstate_t PSTATE_RESET = '{
        phase: PH_REQ, ti: 2'd0, mp: 3'd0, pp: 4'd0, nm: 4'd0, vp: 3'd0,
        keep: 1'b1, tp: TP_IDLE, line_bad: 1'b0, in_token: 1'b0, nul_seen: 1'b0
    };

    function automatic logic [7:0] method_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h47; // G
            2'd1:    ch = 8'h45; // E
            2'd2:    ch = 8'h54; // T
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] path_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h2F; // /
            3'd1:    ch = 8'h68; // h
            3'd2:    ch = 8'h65; // e
            3'd3:    ch = 8'h61; // a
            3'd4:    ch = 8'h6C; // l
            3'd5:    ch = 8'h74; // t
            3'd6:    ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h63; // c
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h6E; // n
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h63; // c
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h69; // i
            4'd8:    ch = 8'h6F; // o
            4'd9:    ch = 8'h6E; // n
            4'd10:   ch = 8'h3A; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] close_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h63; // c
            3'd1:    ch = 8'h6C; // l
            3'd2:    ch = 8'h6F; // o
            3'd3:    ch = 8'h73; // s
            3'd4:    ch = 8'h65; // e
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: hw/rtl/http_request_header_scanner_core.sv
`timescale 1ns / 1ps
// Top level of the HTTP request header scanner: configuration registers, front and back.
// Depends on hrs_pkg, hrs_front and hrs_back.
//
//  channel   handshake                  payload
//  input     push / full                data_byte, first_of_connection
//  result    empty / pop                route_status, keep_conn, consumed_bytes
//  config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One byte per cycle is sustained; the parser takes a queued byte every cycle
// the result queue has room. The last byte of a request is held in the mid queue, and
// its result in the result queue, before the result reaches the result ports. Reset
// clears both queues and the parser and loads max_header_bytes with 4096 and
// max_line_bytes with 255. cfg_ready is always high. A full result queue stalls the
// parser, and the mid queue then fills and raises full.
module http_request_header_scanner_core #(
    parameter int COUNT_BITS = 13,
    parameter int MID_DEPTH  = 2,
    parameter int OUT_DEPTH  = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [7:0]                         data_byte,
    input  logic                               first_of_connection,
    input  logic                               push,
    output logic                               full,
    output logic [2:0]                         route_status,
    output logic                               keep_conn,
    output logic [hrs_pkg::OUT_BYTES_W-1:0]    consumed_bytes,
    output logic                               empty,
    input  logic                               pop,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [hrs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    logic [hrs_pkg::MAX_HDR_W-1:0]  max_header_bytes_reg, max_header_bytes_next;
    logic [hrs_pkg::MAX_LINE_W-1:0] max_line_bytes_reg, max_line_bytes_next;
    hrs_pkg::hrs_sym_t              sym;
    logic                           sym_empty, sym_take;
    hrs_pkg::hrs_result_t           result;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        max_header_bytes_next = max_header_bytes_reg;
        max_line_bytes_next   = max_line_bytes_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hrs_pkg::CFG_MAX_HEADER:
                begin
                    max_header_bytes_next = cfg_data[hrs_pkg::MAX_HDR_W-1:0];
                end
                hrs_pkg::CFG_MAX_LINE:
                begin
                    max_line_bytes_next = cfg_data[hrs_pkg::MAX_LINE_W-1:0];
                end
                default:
                begin
                    max_header_bytes_next = max_header_bytes_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_header_bytes_reg <= hrs_pkg::MAX_HDR_RESET;
            max_line_bytes_reg   <= hrs_pkg::MAX_LINE_RESET;
        end
        else
        begin
            max_header_bytes_reg <= max_header_bytes_next;
            max_line_bytes_reg   <= max_line_bytes_next;
        end
    end

    hrs_front #(
        .MID_DEPTH(MID_DEPTH)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .data_byte          (data_byte),
        .first_of_connection(first_of_connection),
        .push               (push),
        .full               (full),
        .sym_take           (sym_take),
        .sym                (sym),
        .sym_empty          (sym_empty)
    );

    hrs_back #(
        .COUNT_BITS(COUNT_BITS),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .max_header_bytes(max_header_bytes_reg),
        .max_line_bytes  (max_line_bytes_reg),
        .sym             (sym),
        .sym_empty       (sym_empty),
        .sym_take        (sym_take),
        .pop             (pop),
        .empty           (empty),
        .result          (result)
    );

    assign route_status   = result.status;
    assign keep_conn      = result.keep;
    assign consumed_bytes = result.bytes;

endmodule

// File: hw/rtl/hrs_fifo.sv
`timescale 1ns / 1ps
// Small synchronous register FIFO used for the mid queue and the result queue.
// Standalone; DEPTH must be a power of two of at least two.
module hrs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/hrs_front.sv
`timescale 1ns / 1ps
// Front end: accepts received bytes, classifies them and queues them for the parser.
// Depends on hrs_pkg and hrs_fifo.
module hrs_front #(
    parameter int MID_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        data_byte,
    input  logic              first_of_connection,
    input  logic              push,
    output logic              full,
    input  logic              sym_take,
    output hrs_pkg::hrs_sym_t sym,
    output logic              sym_empty
);
    hrs_pkg::hrs_sym_t cls;
    logic [$bits(hrs_pkg::hrs_sym_t)-1:0] sym_bits;

    always_comb
    begin
        cls.raw      = data_byte;
        cls.lower    = data_byte;
        if (data_byte inside {[8'h41:8'h5A]})
        begin
            cls.lower = data_byte | 8'h20;
        end
        cls.is_cr    = (data_byte == hrs_pkg::CH_CR);
        cls.is_lf    = (data_byte == hrs_pkg::CH_LF);
        // Space plus tab, LF, VT, FF and CR
        cls.is_space = (data_byte == hrs_pkg::CH_SP) || (data_byte inside {[8'h09:8'h0D]});
        cls.is_blank = (data_byte == hrs_pkg::CH_SP) || (data_byte == hrs_pkg::CH_TAB);
        cls.is_nul   = (data_byte == hrs_pkg::CH_NUL);
        cls.first    = first_of_connection;
    end

    hrs_fifo #(
        .WIDTH($bits(hrs_pkg::hrs_sym_t)),
        .DEPTH(MID_DEPTH)
    ) u_mid_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(cls),
        .full     (full),
        .pop      (sym_take),
        .pop_data (sym_bits),
        .empty    (sym_empty)
    );

    assign sym = hrs_pkg::hrs_sym_t'(sym_bits);

endmodule

// File: hw/rtl/hrs_back.sv
`timescale 1ns / 1ps
// Back end: the request and header parser, one classified byte per beat, plus the result queue.
// Depends on hrs_pkg and hrs_fifo.
module hrs_back #(
    parameter int COUNT_BITS = 13,
    parameter int OUT_DEPTH  = 2
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [hrs_pkg::MAX_HDR_W-1:0]          max_header_bytes,
    input  logic [hrs_pkg::MAX_LINE_W-1:0]         max_line_bytes,
    input  hrs_pkg::hrs_sym_t                      sym,
    input  logic                                   sym_empty,
    output logic                                   sym_take,
    input  logic                                   pop,
    output logic                                   empty,
    output hrs_pkg::hrs_result_t                   result
);
    localparam int CMP_W = (COUNT_BITS > hrs_pkg::MAX_HDR_W) ? COUNT_BITS : hrs_pkg::MAX_HDR_W;
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};

    hrs_pkg::hrs_pstate_t  st_reg, st_next, cur;
    logic [COUNT_BITS-1:0] bc_reg, bc_next, cur_bc, bc_inc;
    logic [COUNT_BITS-1:0] ll_reg, ll_next, cur_ll, line_len;
    logic                  prev_cr, done, too_large, res_push, res_full, do_match;
    logic [1:0]            tok;
    hrs_pkg::hrs_result_t  res;
    logic [$bits(hrs_pkg::hrs_result_t)-1:0] result_bits;

    // A byte is taken only when the result queue can hold whatever it causes
    assign sym_take = !sym_empty && !res_full;

    always_comb
    begin
        cur      = sym.first ? hrs_pkg::PSTATE_RESET : st_reg;
        cur_bc   = sym.first ? '0 : bc_reg;
        cur_ll   = sym.first ? '0 : ll_reg;
        bc_inc   = (cur_bc != COUNT_TOP) ? cur_bc + 1'b1 : cur_bc;
        prev_cr  = (cur.tp == hrs_pkg::TP_CR) || (cur.tp == hrs_pkg::TP_CRLFCR);
        st_next  = cur;
        ll_next  = cur_ll;
        line_len = cur_ll - 1'b1;
        do_match = 1'b0;
        tok      = cur.ti;

        if (cur.phase == hrs_pkg::PH_REQ)
        begin
            if (sym.is_lf && prev_cr)
            begin
                // The counted length includes the CR, which the limit leaves out
                if (line_len > COUNT_BITS'(max_line_bytes) || cur.ti != hrs_pkg::TOK_LAST)
                begin
                    st_next.line_bad = 1'b1;
                end
                st_next.phase = hrs_pkg::PH_HDR;
            end
            else
            begin
                if (cur_ll != COUNT_TOP)
                begin
                    ll_next = cur_ll + 1'b1;
                end
                if (!cur.nul_seen)
                begin
                    if (sym.is_nul)
                    begin
                        st_next.nul_seen = 1'b1;
                        st_next.in_token = 1'b0;
                    end
                    else if (sym.is_space)
                    begin
                        st_next.in_token = 1'b0;
                    end
                    else if (!cur.in_token)
                    begin
                        st_next.in_token = 1'b1;
                        if (cur.ti != hrs_pkg::TOK_LAST)
                        begin
                            tok        = cur.ti + 1'b1;
                            st_next.ti = tok;
                            do_match   = 1'b1;
                        end
                    end
                    else if (cur.ti != hrs_pkg::TOK_LAST)
                    begin
                        do_match = 1'b1;
                    end
                end
                if (do_match && tok == hrs_pkg::TOK_METHOD)
                begin
                    if (cur.mp < hrs_pkg::METHOD_FULL
                        && sym.raw == hrs_pkg::method_char(cur.mp[1:0]))
                    begin
                        st_next.mp = cur.mp + 1'b1;
                    end
                    else
                    begin
                        st_next.mp = hrs_pkg::METHOD_DEAD;
                    end
                end
                else if (do_match && tok == hrs_pkg::TOK_PATH)
                begin
                    if (cur.pp < hrs_pkg::PATH_FULL
                        && sym.raw == hrs_pkg::path_char(cur.pp[2:0]))
                    begin
                        st_next.pp = cur.pp + 1'b1;
                    end
                    else
                    begin
                        st_next.pp = hrs_pkg::PATH_DEAD;
                    end
                end
            end
        end
        else
        begin
            if (sym.is_lf && prev_cr)
            begin
                st_next.nm = '0;
                st_next.vp = '0;
            end
            else if (cur.nm < hrs_pkg::NAME_FULL)
            begin
                if (sym.lower == hrs_pkg::name_char(cur.nm))
                begin
                    st_next.nm = cur.nm + 1'b1;
                end
                else
                begin
                    st_next.nm = hrs_pkg::NAME_DEAD;
                end
            end
            else if (cur.nm == hrs_pkg::NAME_FULL)
            begin
                // Blanks before the value are skipped
                if (!(cur.vp == '0 && sym.is_blank) && cur.vp < hrs_pkg::VALUE_FULL)
                begin
                    if (sym.lower == hrs_pkg::close_char(cur.vp))
                    begin
                        st_next.vp = cur.vp + 1'b1;
                        if (cur.vp + 1'b1 == hrs_pkg::VALUE_FULL)
                        begin
                            st_next.keep = 1'b0;
                        end
                    end
                    else
                    begin
                        st_next.vp = hrs_pkg::VALUE_DEAD;
                    end
                end
            end
        end

        done = 1'b0;
        case (cur.tp)
            hrs_pkg::TP_CR:
            begin
                st_next.tp = sym.is_lf ? hrs_pkg::TP_CRLF
                           : (sym.is_cr ? hrs_pkg::TP_CR : hrs_pkg::TP_IDLE);
            end
            hrs_pkg::TP_CRLF:
            begin
                st_next.tp = sym.is_cr ? hrs_pkg::TP_CRLFCR : hrs_pkg::TP_IDLE;
            end
            hrs_pkg::TP_CRLFCR:
            begin
                done       = sym.is_lf;
                st_next.tp = sym.is_cr ? hrs_pkg::TP_CR : hrs_pkg::TP_IDLE;
            end
            default:
            begin
                st_next.tp = sym.is_cr ? hrs_pkg::TP_CR : hrs_pkg::TP_IDLE;
            end
        endcase

        too_large = !done && ((CMP_W'(bc_inc) >= CMP_W'(max_header_bytes))
                              || bc_inc == COUNT_TOP);

        res.status = hrs_pkg::ST_TOO_LARGE;
        res.keep   = 1'b0;
        res.bytes  = '0;
        if (done)
        begin
            if (cur.line_bad || CMP_W'(bc_inc) > CMP_W'(max_header_bytes))
            begin
                res.status = hrs_pkg::ST_BAD_REQ;
            end
            else
            begin
                res.keep  = cur.keep;
                res.bytes = hrs_pkg::OUT_BYTES_W'(bc_inc);
                if (cur.mp == hrs_pkg::METHOD_FULL && cur.pp == hrs_pkg::PATH_ROOT)
                begin
                    res.status = hrs_pkg::ST_OK_ROOT;
                end
                else if (cur.mp == hrs_pkg::METHOD_FULL && cur.pp == hrs_pkg::PATH_FULL)
                begin
                    res.status = hrs_pkg::ST_OK_HEALTH;
                end
                else
                begin
                    res.status = hrs_pkg::ST_NOT_FOUND;
                end
            end
        end

        bc_next = bc_inc;
        if (done || too_large)
        begin
            st_next = hrs_pkg::PSTATE_RESET;
            bc_next = '0;
            ll_next = '0;
        end
    end

    assign res_push = sym_take && (done || too_large);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= hrs_pkg::PSTATE_RESET;
            bc_reg <= '0;
            ll_reg <= '0;
        end
        else if (sym_take)
        begin
            st_reg <= st_next;
            bc_reg <= bc_next;
            ll_reg <= ll_next;
        end
    end

    hrs_fifo #(
        .WIDTH($bits(hrs_pkg::hrs_result_t)),
        .DEPTH(OUT_DEPTH)
    ) u_res_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .push_data(res),
        .full     (res_full),
        .pop      (pop),
        .pop_data (result_bits),
        .empty    (empty)
    );

    assign result = hrs_pkg::hrs_result_t'(result_bits);

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && (res.status == hrs_pkg::ST_BAD_REQ || res.status == hrs_pkg::ST_TOO_LARGE)
        |-> !res.keep && res.bytes == '0)
        else $error("error result carries keep-alive or a byte count");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> bc_reg == '0 && ll_reg == '0 && st_reg.phase == hrs_pkg::PH_REQ)
        else $error("parser did not restart after a result");

    a_short_line_bad: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.phase == hrs_pkg::PH_HDR && st_reg.ti != hrs_pkg::TOK_LAST |-> st_reg.line_bad)
        else $error("request line with too few tokens not marked bad");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_full |-> !res_push)
        else $error("result pushed into a full queue");

endmodule
